// ===== hdl/mpeg_audio_duration_estimator_top_macros.svh =====
// Assertion macros for the duration estimator controller (made_ctrl).
// Depends on nothing; included by files that carry assertions.
`ifndef MPEG_AUDIO_DURATION_ESTIMATOR_TOP_MACROS_SVH
`define MPEG_AUDIO_DURATION_ESTIMATOR_TOP_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define MADE_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define MADE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/made_pkg.sv =====
// Types, codes and decode tables for the duration estimator.
// No dependencies; used by every module of the block.
package made_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } made_in_t;

    typedef struct packed {
        logic        header_found;
        logic [8:0]  bitrate_kbps;
        logic        duration_valid;
        logic        from_frame_count;
        logic [30:0] duration_seconds;
    } made_out_t;

    typedef enum logic [1:0] {
        PH_SEARCH  = 2'd0,
        PH_TAG     = 2'd1,
        PH_COUNTED = 2'd2
    } made_phase_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_MUL    = 3'd1,
        ST_DIV    = 3'd2,
        ST_OUT    = 3'd3
    } made_state_t;

    localparam logic CFG_FILE_SIZE = 1'b0;
    localparam logic CFG_AUDIO_OFS = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic take_byte;
        logic start_mul;
        logic start_div;
        logic div_step;
        logic load_out;
    } made_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
    } made_sts_t;

    function automatic logic [8:0] rate_v1(input logic [3:0] ix);
        logic [8:0] r;
        unique case (ix)
            4'd1: r = 9'd32;   4'd2: r = 9'd40;   4'd3: r = 9'd48;
            4'd4: r = 9'd56;   4'd5: r = 9'd64;   4'd6: r = 9'd80;
            4'd7: r = 9'd96;   4'd8: r = 9'd112;  4'd9: r = 9'd128;
            4'd10: r = 9'd160; 4'd11: r = 9'd192; 4'd12: r = 9'd224;
            4'd13: r = 9'd256; 4'd14: r = 9'd320;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [8:0] rate_v2(input logic [3:0] ix);
        logic [8:0] r;
        unique case (ix)
            4'd1: r = 9'd8;    4'd2: r = 9'd16;   4'd3: r = 9'd24;
            4'd4: r = 9'd32;   4'd5: r = 9'd40;   4'd6: r = 9'd48;
            4'd7: r = 9'd56;   4'd8: r = 9'd64;   4'd9: r = 9'd80;
            4'd10: r = 9'd96;  4'd11: r = 9'd112; 4'd12: r = 9'd128;
            4'd13: r = 9'd144; 4'd14: r = 9'd160;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] freq_tab(input logic v1, input logic [1:0] ix);
        logic [15:0] f;
        unique case ({v1, ix})
            3'b100: f = 16'd44100;
            3'b101: f = 16'd48000;
            3'b110: f = 16'd32000;
            3'b000: f = 16'd22050;
            3'b001: f = 16'd24000;
            3'b010: f = 16'd16000;
            default: f = 16'd0;
        endcase
        return f;
    endfunction

endpackage

// ===== hdl/made_ctrl.sv =====
// Sequencer for the duration estimator: byte intake, then multiply, divide and result load.
// Depends on made_pkg and the assertion macros header.
`include "mpeg_audio_duration_estimator_top_macros.svh"
module made_ctrl
    import made_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic      last_in,
    output logic      m_valid,
    input  logic      m_ready,
    output made_cmd_t cmd,
    input  made_sts_t sts
);
    made_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.take_byte = s_valid;
                if (s_valid && last_in) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.start_mul = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                // one quotient bit per cycle until the divider reports done
                cmd.div_step = 1'b1;
                if (sts.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // wait for the output register to free up
                if (!m_valid_next) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid = m_valid_reg;

    `MADE_ASSERT_IMPL(a_no_take_busy, aclk, aresetn,
        state_reg != ST_IDLE, !s_ready, "ready while busy")
    `MADE_ASSERT_NEXT(a_last_starts, aclk, aresetn,
        s_valid && s_ready && last_in, state_reg == ST_MUL, "last byte not followed by compute")
    `MADE_ASSERT_NEXT(a_load_valid, aclk, aresetn,
        cmd.load_out, m_valid_reg, "load without valid")
endmodule

// ===== hdl/made_dp.sv =====
// Datapath: byte window, header and tag scan, frame product and serial divider.
// Depends on made_pkg.
module made_dp
    import made_pkg::*;
#(
    parameter int HeaderSearchLimit = 8192,
    parameter int TagSearchSpan     = 200
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  made_in_t    in_word,
    input  logic [30:0] file_size,
    input  logic [30:0] audio_ofs,
    input  made_cmd_t   cmd,
    output made_sts_t   sts,
    output made_out_t   out_word
);
    localparam int PosCap = HeaderSearchLimit + TagSearchSpan + 16;
    localparam int PW     = $clog2(PosCap + 1);
    localparam int HW     = $clog2(HeaderSearchLimit);

    logic [7:0]  win_reg [13];
    logic [PW-1:0] pos_reg;
    made_phase_t phase_reg;
    logic [HW-1:0] hpos_reg;
    logic [8:0]  rate_reg;
    logic [15:0] freq_reg;
    logic        long_reg;
    logic [31:0] frames_reg;

    // snapshot of stream result, taken at the last byte
    made_phase_t fph_reg;
    logic [8:0]  frate_reg;
    logic [15:0] ffreq_reg;
    logic        flong_reg;
    logic [31:0] fframes_reg;
    logic        size_ok_reg;
    logic [30:0] size_diff_reg;

    logic [31:0] dvd_reg;   // dividend shifting into quotient
    logic [31:0] rem_reg;
    logic [16:0] dsr_reg;
    logic [5:0]  cnt_reg;
    logic        div_run_reg;
    made_out_t   out_reg;

    logic [7:0] w [13];
    always_comb begin
        for (int i = 0; i < 12; i++) w[i] = win_reg[i + 1];
        w[12] = in_word.data_byte;
    end

    // header decode on shifted window
    logic [1:0]  ver, lay, frix;
    logic [3:0]  brix;
    logic [8:0]  hrate;
    logic [15:0] hfreq;
    logic        hdr_ok, tag_ok, in_hwin, in_twin;
    logic [PW:0] jpos;
    always_comb begin
        ver   = w[9][4:3];
        lay   = w[9][2:1];
        brix  = w[10][7:4];
        frix  = w[10][3:2];
        hrate = (ver == 2'd3) ? rate_v1(brix) : rate_v2(brix);
        hfreq = freq_tab(ver == 2'd3, frix);
        hdr_ok = (w[8] == 8'hff) && ((w[9] & 8'he0) == 8'he0) && (ver != 2'd1)
              && (lay == 2'd1) && (hrate != 9'd0) && (hfreq != 16'd0);
        in_hwin = (pos_reg >= PW'(4)) && ((pos_reg - PW'(4)) < PW'(HeaderSearchLimit));
        tag_ok = (((w[0] == "X") && (w[1] == "i") && (w[2] == "n") && (w[3] == "g"))
               || ((w[0] == "I") && (w[1] == "n") && (w[2] == "f") && (w[3] == "o")))
               && w[7][0] && ({w[8], w[9], w[10], w[11]} != 32'd0);
        jpos   = {1'b0, pos_reg} - (PW+1)'(12);
        in_twin = (pos_reg >= PW'(12))
               && (jpos >= (PW+1)'(hpos_reg) + (PW+1)'(4))
               && (jpos < (PW+1)'(hpos_reg) + (PW+1)'(TagSearchSpan));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            phase_reg <= PH_SEARCH;
            for (int i = 0; i < 13; i++) win_reg[i] <= 8'd0;
            hpos_reg <= '0; rate_reg <= '0; freq_reg <= '0;
            long_reg <= 1'b0; frames_reg <= '0;
        end else if (cmd.take_byte) begin
            if (in_word.last_byte) begin
                pos_reg   <= '0;
                phase_reg <= PH_SEARCH;
                for (int i = 0; i < 13; i++) win_reg[i] <= 8'd0;
                hpos_reg <= '0; rate_reg <= '0; freq_reg <= '0;
                long_reg <= 1'b0; frames_reg <= '0;
            end else begin
                for (int i = 0; i < 13; i++) win_reg[i] <= w[i];
                if (pos_reg < PW'(PosCap)) pos_reg <= pos_reg + PW'(1);
                if (phase_reg == PH_SEARCH && in_hwin && hdr_ok) begin
                    rate_reg  <= hrate;
                    freq_reg  <= hfreq;
                    long_reg  <= (ver == 2'd3);
                    hpos_reg  <= HW'(pos_reg - PW'(4));
                    phase_reg <= PH_TAG;
                end else if (phase_reg == PH_TAG && in_twin && tag_ok) begin
                    frames_reg <= {w[8], w[9], w[10], w[11]};
                    phase_reg  <= PH_COUNTED;
                end
            end
        end
    end

    // snapshot includes the last byte's own scan
    always_ff @(posedge aclk) begin
        if (cmd.take_byte && in_word.last_byte) begin
            fph_reg     <= phase_reg;
            frate_reg   <= rate_reg;
            ffreq_reg   <= freq_reg;
            flong_reg   <= long_reg;
            fframes_reg <= frames_reg;
            if (phase_reg == PH_SEARCH && in_hwin && hdr_ok) begin
                fph_reg   <= PH_TAG;
                frate_reg <= hrate;
                ffreq_reg <= hfreq;
                flong_reg <= (ver == 2'd3);
            end else if (phase_reg == PH_TAG && in_twin && tag_ok) begin
                fph_reg     <= PH_COUNTED;
                fframes_reg <= {w[8], w[9], w[10], w[11]};
            end
            size_ok_reg   <= file_size > audio_ofs;
            size_diff_reg <= file_size - audio_ofs;
        end
    end

    // frames*1152 = (f<<10)+(f<<7); frames*576 = (f<<9)+(f<<6)
    logic [31:0] prod;
    assign prod = flong_reg ? ((fframes_reg << 10) + (fframes_reg << 7))
                            : ((fframes_reg << 9) + (fframes_reg << 6));

    // (d / 125) / rate equals d / (125 * rate) for whole numbers; 125r = 128r - 4r + r
    logic [16:0] rate125;
    assign rate125 = ({8'd0, frate_reg} << 7) - ({8'd0, frate_reg} << 2) + {8'd0, frate_reg};

    logic [32:0] trial;
    assign trial = {rem_reg, dvd_reg[31]} - {16'd0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_run_reg <= 1'b0;
            cnt_reg     <= '0;
        end else if (cmd.start_mul) begin
            rem_reg     <= '0;
            cnt_reg     <= 6'd32;
            div_run_reg <= 1'b1;
            if (fph_reg == PH_COUNTED) begin
                dvd_reg <= prod;
                dsr_reg <= {1'b0, ffreq_reg};
            end else begin
                dvd_reg <= {1'b0, size_diff_reg};
                dsr_reg <= rate125;
            end
        end else if (cmd.div_step && div_run_reg) begin
            if (cnt_reg != 6'd0) begin
                // restoring divide, one quotient bit per cycle
                if (!trial[32]) begin
                    rem_reg <= trial[31:0];
                    dvd_reg <= {dvd_reg[30:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[30:0], dvd_reg[31]};
                    dvd_reg <= {dvd_reg[30:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 6'd1;
            end else begin
                div_run_reg <= 1'b0;
            end
        end
    end

    assign sts.div_done = div_run_reg && (cnt_reg == 6'd0);

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg.header_found     <= (fph_reg != PH_SEARCH);
            out_reg.bitrate_kbps     <= (fph_reg != PH_SEARCH) ? frate_reg : 9'd0;
            out_reg.from_frame_count <= (fph_reg == PH_COUNTED);
            if (fph_reg == PH_COUNTED) begin
                out_reg.duration_valid   <= 1'b1;
                out_reg.duration_seconds <= dvd_reg[30:0];
            end else if (fph_reg == PH_TAG && size_ok_reg) begin
                out_reg.duration_valid   <= 1'b1;
                out_reg.duration_seconds <= dvd_reg[30:0];
            end else begin
                out_reg.duration_valid   <= 1'b0;
                out_reg.duration_seconds <= '0;
            end
        end
    end

    assign out_word = out_reg;
endmodule

// ===== hdl/mpeg_audio_duration_estimator_top.sv =====
// Top level of the MP3 duration estimator: config registers, controller, datapath.
// Depends on made_pkg, made_ctrl and made_dp.
// Bytes are taken one per cycle while scanning. After the byte marked last the
// block is busy: it sets up, runs a one-bit-per-cycle divide (by the sample
// rate for a frame count, by 125 times the bitrate for a size estimate),
// finishes and loads the result word. The load waits while the previous
// result word has not been taken. Then the block presents the result and
// returns to taking bytes.
module mpeg_audio_duration_estimator_top
    import made_pkg::*;
#(
    parameter int HEADER_SEARCH_LIMIT = 8192,
    parameter int TAG_SEARCH_SPAN     = 200
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  made_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output made_out_t   m_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [30:0] cfg_wdata
);
    logic [30:0] file_size_reg, audio_ofs_reg;
    made_cmd_t   cmd;
    made_sts_t   sts;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_size_reg <= '0;
            audio_ofs_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FILE_SIZE: file_size_reg <= cfg_wdata;
                CFG_AUDIO_OFS: audio_ofs_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    made_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .last_in (s_data.last_byte),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    made_dp #(
        .HeaderSearchLimit (HEADER_SEARCH_LIMIT),
        .TagSearchSpan     (TAG_SEARCH_SPAN)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_word   (s_data),
        .file_size (file_size_reg),
        .audio_ofs (audio_ofs_reg),
        .cmd       (cmd),
        .sts       (sts),
        .out_word  (m_data)
    );
endmodule
